@@ hdl/hmmd_pkg.sv @@
// Shared types and constants for the handheld memory map decoder.
// No dependencies; imported by every module of the block but hmmd_ram.
`timescale 1ns / 1ps

package hmmd_pkg;

	// target codes carried in a response
	localparam logic [2:0] TGT_LOCAL  = 3'd0;
	localparam logic [2:0] TGT_BOOT   = 3'd1;
	localparam logic [2:0] TGT_CART   = 3'd2;
	localparam logic [2:0] TGT_VIDEO  = 3'd3;
	localparam logic [2:0] TGT_JOYPAD = 3'd4;

	// local store selected by the front end
	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_WRAM = 3'd1;
	localparam logic [2:0] ST_IO   = 3'd2;
	localparam logic [2:0] ST_HRAM = 3'd3;
	localparam logic [2:0] ST_IE   = 3'd4;

	// local index width: work RAM and its echo share the low 13 address bits
	localparam int LCL_AW = 13;

	localparam logic [15:0] ADDR_JOYPAD      = 16'hFF00;
	localparam logic [15:0] ADDR_BOOT_UNMAP  = 16'hFF50;

	typedef struct packed {
		logic        op;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} req_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [15:0] fwd_addr;
		logic [7:0]  fwd_data;
		logic        fwd_write;
		logic [7:0]  rdata;
		logic        range_error;
	} rsp_t;

	// decoded transaction passed from front end to back end
	typedef struct packed {
		rsp_t              res;
		logic [2:0]        sel;
		logic              wr;
		logic [LCL_AW-1:0] idx;
		logic [7:0]        data;
	} entry_t;

endpackage

@@ hdl/handheld_memory_map_decoder.sv @@
// A request passes a queue slot and then the response register before rsp_valid rises.
// Throughput: one per clock when not stalled, set by each RAM's single registered port.
// Reset (arst_n low, async): boot ROM mapped, interrupt-enable cleared, queue and
// response emptied. RAM contents are not cleared and need no clearing pass.
// Depends on hmmd_pkg, hmmd_front, hmmd_queue, hmmd_back, hmmd_ram.
`timescale 1ns / 1ps

module handheld_memory_map_decoder import hmmd_pkg::*; #(
	parameter int WORK_RAM_BYTES = 8192,
	parameter int IO_BYTES       = 76,
	parameter int HIGH_RAM_BYTES = 127
) (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	// response channel
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// front end to queue
	entry_t f_entry;
	logic   f_push;
	// queue to back end
	entry_t q_head;
	logic   q_full;
	logic   q_empty;
	logic   b_pop;

	// Decode happens in the request cycle; the boot-unmap flag lives here so
	// that the very next request sees an unmap write.
	hmmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.push      (f_push),
		.entry     (f_entry)
	);

	// Two entries keep the request side flowing while a response is stalled.
	hmmd_queue #(.DEPTH(2)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wentry (f_entry),
		.pop    (b_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end performs local store accesses in order; a write followed by a
	// read of the same byte sees the new value since the write reaches the RAM first.
	hmmd_back #(
		.WORK_RAM_BYTES (WORK_RAM_BYTES),
		.IO_BYTES       (IO_BYTES),
		.HIGH_RAM_BYTES (HIGH_RAM_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.empty     (q_empty),
		.pop       (b_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ hdl/hmmd_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hmmd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/hmmd_front.sv @@
// Front end: address decode of bus requests and the boot-unmap flag.
// Depends on hmmd_pkg.
`timescale 1ns / 1ps

module hmmd_front import hmmd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  req_t   req,
	input  logic   q_full,
	output logic   push,
	output entry_t entry
);

	logic        boot_unmapped_q;
	logic        fwd;
	logic [2:0]  tgt;
	logic        err;
	logic [15:0] a;
	logic        wr;

	assign req_stall = q_full;
	assign push      = req_valid && !q_full;
	assign a         = req.addr;
	assign wr        = req.op;

	always_comb begin
		entry       = '0;
		entry.wr    = wr;
		entry.idx   = a[LCL_AW-1:0];
		entry.data  = req.wdata;
		entry.sel   = ST_NONE;
		fwd         = 1'b0;
		tgt         = TGT_LOCAL;
		err         = 1'b0;
		if (a < 16'h8000) begin
			if (!boot_unmapped_q && a[15:8] == 8'h00) begin
				// boot ROM is read-only
				if (wr) begin
					err = 1'b1;
				end else begin
					fwd = 1'b1;
					tgt = TGT_BOOT;
				end
			end else begin
				fwd = 1'b1;
				tgt = TGT_CART;
			end
		end else if (a < 16'hA000) begin
			fwd = 1'b1;
			tgt = TGT_VIDEO;
		end else if (a < 16'hC000) begin
			fwd = 1'b1;
			tgt = TGT_CART;
		end else if (a < 16'hFE00) begin
			entry.sel = ST_WRAM;
		end else if (a < 16'hFEA0) begin
			fwd = 1'b1;
			tgt = TGT_VIDEO;
		end else if (a < 16'hFF00) begin
			err = 1'b1;
		end else if (a < 16'hFF4C) begin
			if (a == ADDR_JOYPAD) begin
				fwd = 1'b1;
				tgt = TGT_JOYPAD;
			end else if (a >= 16'hFF40) begin
				fwd = 1'b1;
				tgt = TGT_VIDEO;
			end else begin
				entry.sel = ST_IO;
			end
		end else if (a < 16'hFF80) begin
			// only a write to the boot-unmap flag is legal here
			if (!(wr && a == ADDR_BOOT_UNMAP)) begin
				err = 1'b1;
			end
		end else if (a < 16'hFFFF) begin
			entry.sel = ST_HRAM;
		end else begin
			entry.sel = ST_IE;
		end

		if (fwd) begin
			entry.res.target    = tgt;
			entry.res.fwd_addr  = a;
			entry.res.fwd_data  = wr ? req.wdata : 8'h00;
			entry.res.fwd_write = wr;
		end
		entry.res.range_error = err;
	end

	// flag is updated in request order, so later decodes see it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_unmapped_q <= 1'b0;
		end else if (push && wr && a == ADDR_BOOT_UNMAP) begin
			boot_unmapped_q <= (req.wdata != 8'h00);
		end
	end

endmodule

@@ hdl/hmmd_queue.sv @@
// Short FIFO between the decode front end and the execution back end.
// Depends on hmmd_pkg.
`timescale 1ns / 1ps

module hmmd_queue import hmmd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wentry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wentry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/hmmd_back.sv @@
// Back end: local stores, interrupt-enable byte and the response register.
// Depends on hmmd_pkg and hmmd_ram.
`timescale 1ns / 1ps

module hmmd_back import hmmd_pkg::*; #(
	parameter int WORK_RAM_BYTES = 8192,
	parameter int IO_BYTES       = 76,
	parameter int HIGH_RAM_BYTES = 127
) (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   empty,
	output logic   pop,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	localparam int WA = $clog2(WORK_RAM_BYTES);
	localparam int IA = $clog2(IO_BYTES);
	localparam int HA = $clog2(HIGH_RAM_BYTES);

	logic       valid_q;
	logic [7:0] ie_q;
	rsp_t       res_s2;
	logic [2:0] src_s2;
	logic [7:0] ie_s2;
	logic [7:0] wram_rd;
	logic [7:0] io_rd;
	logic [7:0] hram_rd;
	logic [7:0] rd_sel;

	assign pop = !empty && (!valid_q || !rsp_stall);

	hmmd_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
		.clk   (clk),
		.en    (pop && head.sel == ST_WRAM),
		.we    (head.wr),
		.addr  (head.idx[WA-1:0]),
		.wdata (head.data),
		.rdata (wram_rd)
	);

	hmmd_ram #(.WIDTH(8), .DEPTH(IO_BYTES)) u_io (
		.clk   (clk),
		.en    (pop && head.sel == ST_IO),
		.we    (head.wr),
		.addr  (head.idx[IA-1:0]),
		.wdata (head.data),
		.rdata (io_rd)
	);

	hmmd_ram #(.WIDTH(8), .DEPTH(HIGH_RAM_BYTES)) u_hram (
		.clk   (clk),
		.en    (pop && head.sel == ST_HRAM),
		.we    (head.wr),
		.addr  (head.idx[HA-1:0]),
		.wdata (head.data),
		.rdata (hram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ie_q    <= 8'h00;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
			if (pop && head.sel == ST_IE && head.wr) begin
				ie_q <= head.data;
			end
		end
	end

	// RAM read data registers only move on pop, so they hold under stall
	always_ff @(posedge clk) begin
		if (pop) begin
			res_s2 <= head.res;
			src_s2 <= head.wr ? ST_NONE : head.sel;
			ie_s2  <= ie_q;
		end
	end

	always_comb begin
		case (src_s2)
			ST_WRAM: rd_sel = wram_rd;
			ST_IO:   rd_sel = io_rd;
			ST_HRAM: rd_sel = hram_rd;
			ST_IE:   rd_sel = ie_s2;
			default: rd_sel = 8'h00;
		endcase
	end

	always_comb begin
		rsp       = res_s2;
		rsp.rdata = rd_sel;
	end

	assign rsp_valid = valid_q;

endmodule

@@ hdl/hmmd_checker.sv @@
// Port-level checks for the memory map decoder, bound to the top level.
// Depends on hmmd_pkg and handheld_memory_map_decoder.
`timescale 1ns / 1ps

module hmmd_checker import hmmd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic [2:0] outstanding_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_acc && !rsp_acc) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (rsp_acc && !req_acc) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed under stall");

	// no response without an accepted request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 3'd0)
		else $error("response without request");

	// queue plus output register bound the transactions in flight
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'd3)
		else $error("too many transactions in flight");

	// boot ROM is read-only and covers the low page only
	a_boot_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.target == TGT_BOOT |-> !rsp.fwd_write && rsp.fwd_addr[15:8] == 8'h00)
		else $error("bad boot ROM forward");

endmodule

bind handheld_memory_map_decoder hmmd_checker u_chk (.*);
